// ===== rtl/core/dpf_pkg.sv =====
// Package with shared types and constants of the duplicate packet filter.
`default_nettype none
package dpf_pkg;
    localparam int HIST_MAX_DEF   = 20;
    localparam int WINDOW_MAX_DEF = 40;
    localparam int MAX_LEN_DEF    = 2048;
    localparam int DEPTH_RST      = 10;
    localparam int WINDOW_RST     = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 6;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] time_seconds;
    } t_in_word;

    typedef struct packed {
        logic        forward;
        logic [11:0] packet_length;
        logic [5:0]  match_age;
        logic        overlong;
    } t_out_word;
endpackage
`default_nettype wire

// ===== rtl/core/duplicate_packet_filter.sv =====
// Top level of the duplicate packet filter: byte memory, compare flags and search.
`default_nettype none
// Usage: drive i_start with one payload word (byte, last mark, time) per cycle.
// A word is taken when i_start is high and o_busy is low. Bytes are written
// into a history memory and compared against all stored packets; each byte
// passes an accept step and a compare step because the byte memory read is
// registered (read, then compare and write). o_busy is high in the
// cycle after a word is taken. At the last byte a search walks the newest
// history entries one per cycle, newest first, and the result then appears
// on o_result, marked by o_valid for one cycle. There is no back-pressure
// on results; the receiver must take each strobe. Reset clears history
// valid bits, timestamps and lengths at once; the byte memory is not cleared
// since only written entries are ever compared. Configuration is written
// through i_cfg_we, i_cfg_idx, i_cfg_data; the user must do so only while
// idle, the block does not enforce it; depth and window saturate at their maxima.
module duplicate_packet_filter #(
    parameter int HIST_MAX   = dpf_pkg::HIST_MAX_DEF,
    parameter int WINDOW_MAX = dpf_pkg::WINDOW_MAX_DEF,
    parameter int MAX_LEN    = dpf_pkg::MAX_LEN_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  dpf_pkg::t_in_word                i_word,
    output logic                             o_busy,
    output logic                             o_valid,
    output dpf_pkg::t_out_word               o_result,
    input  wire                              i_cfg_we,
    input  wire  [dpf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [dpf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dpf_pkg::*;

    localparam int SLOTS = HIST_MAX + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int PW    = $clog2(MAX_LEN + 2);
    localparam int AW    = $clog2(MAX_LEN);

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_SEARCH} t_state;

    t_state                r_state;
    logic [4:0]            r_depth;
    logic [5:0]            r_window;
    logic [SW-1:0]         r_newest;
    logic [PW-1:0]         r_pos;
    logic [SLOTS-1:0]      r_flags;
    logic [SLOTS-1:0]      r_hvalid;
    logic [PW-1:0]         r_hlen [SLOTS];
    logic [31:0]           r_htime [SLOTS];
    logic [7:0]            r_rd [SLOTS];
    t_in_word              r_word;
    logic [PW-1:0]         r_len;
    logic [SW-1:0]         r_j;
    logic [5:0]            r_cnt;
    logic [5:0]            r_lim;
    logic [7:0]            r_win;
    t_out_word             r_res;
    logic                  r_valid;

    logic [SW-1:0]         wslot;
    logic [PW-1:0]         pos_inc;
    logic [31:0]           age;
    logic                  accept;

    assign accept  = i_start && (r_state == S_IDLE);
    assign wslot   = (r_newest == SW'(SLOTS - 1)) ? '0 : r_newest + SW'(1);
    assign pos_inc = (r_pos <= PW'(MAX_LEN)) ? r_pos + PW'(1) : r_pos;
    assign age     = r_word.time_seconds - r_htime[r_j];

    // Byte memory: one bank per slot, read at the current position and
    // written only in the slot that takes the incoming packet.
    for (genvar k = 0; k < SLOTS; k++) begin : g_bank
        logic [7:0] r_mem [MAX_LEN];
        always_ff @(posedge i_clk) begin
            if (r_state == S_CMP && r_pos < PW'(MAX_LEN) && wslot == SW'(k)) begin
                r_mem[r_pos[AW-1:0]] <= r_word.data_byte;
            end
            r_rd[k] <= r_mem[r_pos[AW-1:0]];
        end
    end

    // Control, configuration writes, flag update, search and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= 5'(DEPTH_RST);
            r_window <= 6'(WINDOW_RST);
            r_newest <= SW'(SLOTS - 1);
            r_pos    <= '0;
            r_flags  <= '1;
            r_hvalid <= '0;
            r_valid  <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_hlen[k]  <= '0;
                r_htime[k] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HISTORY_DEPTH:  r_depth  <= i_cfg_data[4:0];
                    REG_WINDOW_SECONDS: r_window <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_word  <= i_word;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    for (int k = 0; k < SLOTS; k++) begin
                        if (r_pos >= PW'(MAX_LEN) || SW'(k) == wslot || !r_hvalid[k] ||
                            r_hlen[k] <= r_pos ||
                            r_rd[k] != r_word.data_byte) begin
                            r_flags[k] <= 1'b0;
                        end
                    end
                    if (!r_word.last_byte) begin
                        r_pos   <= pos_inc;
                        r_state <= S_IDLE;
                    end else begin
                        r_len   <= pos_inc;
                        r_j     <= r_newest;
                        r_cnt   <= '0;
                        r_lim   <= (32'(r_depth) > 32'(HIST_MAX)) ? 6'(HIST_MAX)
                                                                : 6'(r_depth);
                        r_win   <= (32'(r_window) > 32'(WINDOW_MAX)) ? 8'(WINDOW_MAX)
                                                                   : 8'(r_window);
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (r_len > PW'(MAX_LEN) || r_cnt >= r_lim ||
                        (r_hvalid[r_j] && age > 32'(r_win))) begin
                        // Nothing matched: forward, record unless overlong.
                        r_res.forward       <= 1'b1;
                        r_res.match_age     <= '0;
                        r_res.overlong      <= r_len > PW'(MAX_LEN);
                        r_res.packet_length <= (r_len > PW'(MAX_LEN)) ? 12'(MAX_LEN)
                                                                      : 12'(r_len);
                        if (r_len <= PW'(MAX_LEN)) begin
                            r_newest         <= wslot;
                            r_hvalid[wslot]  <= 1'b1;
                            r_hlen[wslot]    <= r_len;
                            r_htime[wslot]   <= r_word.time_seconds;
                        end
                        r_valid <= 1'b1;
                        r_pos   <= '0;
                        r_flags <= '1;
                        r_state <= S_IDLE;
                    end else if (r_hvalid[r_j] && r_flags[r_j] && r_hlen[r_j] == r_len) begin
                        r_res.forward       <= 1'b0;
                        r_res.match_age     <= 6'(age);
                        r_res.overlong      <= 1'b0;
                        r_res.packet_length <= 12'(r_len);
                        r_valid <= 1'b1;
                        r_pos   <= '0;
                        r_flags <= '1;
                        r_state <= S_IDLE;
                    end else begin
                        r_j   <= (r_j == '0) ? SW'(SLOTS - 1) : r_j - SW'(1);
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    // o_valid stays low while a taken word is being compared.
    a_no_res_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_valid) else $error("result right after accept");
    // A dropped packet is never overlong.
    a_drop_not_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.forward) |-> !o_result.overlong)
        else $error("overlong packet dropped");
    // Newest slot is always valid once it changed.
    a_newest_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_newest != $past(r_newest)) |-> r_hvalid[r_newest])
        else $error("newest slot not valid");
endmodule
`default_nettype wire
